// ===== rtl/bbv_pkg.sv =====
// Shared types, constants and the search-key table for the bracket balance validator.
// No dependencies; every other file in rtl/ imports this package.
package bbv_pkg;

    localparam int MAX_BYTES = 1048576;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int MIN_W     = 21;
    localparam int CMP_W     = (CNT_W > MIN_W) ? CNT_W : MIN_W;
    localparam int KEY_LEN   = 13;
    localparam int PROG_W    = 4;

    localparam logic [MIN_W-1:0] MIN_BYTES_RST = MIN_W'(64);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_beat;

    // Characters of the search key, by position.
    function automatic logic [7:0] key_char(input logic [PROG_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h6D; // m
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h64; // d
            4'd3:    c = 8'h73; // s
            4'd4:    c = 8'h5F; // _
            4'd5:    c = 8'h73; // s
            4'd6:    c = 8'h65; // e
            4'd7:    c = 8'h74; // t
            4'd8:    c = 8'h74; // t
            4'd9:    c = 8'h69; // i
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h73; // s
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/bbv_in_reg.sv =====
// Input register of the bracket balance validator: holds one accepted beat.
// Depends on bbv_pkg for the beat type.
module bbv_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  bbv_pkg::t_beat i_beat,
    input  logic          i_advance,
    output logic          o_stall,
    output logic          o_valid,
    output bbv_pkg::t_beat o_beat
);
    import bbv_pkg::*;

    logic   r_valid;
    t_beat  r_beat;
    logic   accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;
endmodule

// ===== rtl/bbv_scan.sv =====
// Text state of the bracket balance validator: length, depths, string and escape flags,
// key search and sticky failure, plus the min_bytes register. Depends on bbv_pkg.
module bbv_scan (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [bbv_pkg::MIN_W-1:0] i_cfg_wr_data,
    input  logic                     i_fire,
    input  bbv_pkg::t_beat           i_beat,
    output logic                     o_verdict
);
    import bbv_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BYTES);
    localparam logic [PROG_W-1:0] KEY_END = PROG_W'(KEY_LEN);

    logic [MIN_W-1:0]  r_min_bytes;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_brace, n_brace;
    logic [CNT_W-1:0]  r_bracket, n_bracket;
    logic              r_in_str, n_in_str;
    logic              r_skip, n_skip;
    logic [PROG_W-1:0] r_prog, n_prog;
    logic              r_key, n_key;
    logic              r_failed, n_failed;
    logic [7:0]        c;

    assign c = i_beat.text_byte;

    always_comb begin
        n_count   = r_count;
        n_brace   = r_brace;
        n_bracket = r_bracket;
        n_in_str  = r_in_str;
        n_skip    = r_skip;
        n_prog    = r_prog;
        n_key     = r_key;
        n_failed  = r_failed;

        if (r_count >= CNT_MAX) begin
            n_failed = 1'b1;
        end else begin
            n_count = r_count + 1'b1;
        end

        // The key has no self-overlap, so a mismatch restarts on its first letter only.
        if (r_prog < KEY_END && c == key_char(r_prog)) begin
            n_prog = r_prog + 1'b1;
        end else if (c == key_char('0)) begin
            n_prog = PROG_W'(1);
        end else begin
            n_prog = '0;
        end
        if (n_prog >= KEY_END) begin
            n_key  = 1'b1;
            n_prog = '0;
        end

        if (r_skip) begin
            n_skip = 1'b0;
        end else if (c == CH_NUL) begin
            n_failed = 1'b1;
        end else if (r_in_str) begin
            if (c == CH_BSLASH) begin
                n_skip = 1'b1;
            end else if (c == CH_QUOTE) begin
                n_in_str = 1'b0;
            end
        end else begin
            case (c)
                CH_QUOTE: n_in_str = 1'b1;
                CH_LBRACE: begin
                    if (r_brace >= CNT_MAX) n_failed = 1'b1;
                    else                    n_brace  = r_brace + 1'b1;
                end
                CH_RBRACE: begin
                    if (r_brace == '0) n_failed = 1'b1;
                    else               n_brace  = r_brace - 1'b1;
                end
                CH_LBRACK: begin
                    if (r_bracket >= CNT_MAX) n_failed  = 1'b1;
                    else                      n_bracket = r_bracket + 1'b1;
                end
                CH_RBRACK: begin
                    if (r_bracket == '0) n_failed  = 1'b1;
                    else                 n_bracket = r_bracket - 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_verdict = !n_failed && n_key
                    && (CMP_W'(n_count) >= CMP_W'(r_min_bytes))
                    && !n_in_str && !n_skip
                    && (n_brace == '0) && (n_bracket == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bytes <= MIN_BYTES_RST;
        end else if (i_cfg_wr_en) begin
            r_min_bytes <= i_cfg_wr_data;
        end
    end

    // The last beat of a text clears everything for the next text.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_beat.last_byte)) begin
            r_count   <= '0;
            r_brace   <= '0;
            r_bracket <= '0;
            r_in_str  <= 1'b0;
            r_skip    <= 1'b0;
            r_prog    <= '0;
            r_key     <= 1'b0;
            r_failed  <= 1'b0;
        end else if (i_fire) begin
            r_count   <= n_count;
            r_brace   <= n_brace;
            r_bracket <= n_bracket;
            r_in_str  <= n_in_str;
            r_skip    <= n_skip;
            r_prog    <= n_prog;
            r_key     <= n_key;
            r_failed  <= n_failed;
        end
    end
endmodule

// ===== rtl/bbv_out_reg.sv =====
// Result register of the bracket balance validator: holds one verdict until taken.
// Depends on bbv_pkg only through the shared import convention.
module bbv_out_reg (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  logic i_verdict,
    input  logic i_stall,
    output logic o_valid,
    output logic o_plausible
);
    import bbv_pkg::*;

    logic r_valid;
    logic r_plausible;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_plausible <= i_verdict;
        end
    end

    assign o_valid     = r_valid;
    assign o_plausible = r_plausible;
endmodule

// ===== rtl/bracket_balance_validator.sv =====
// Bracket balance validator: takes a text one byte per beat and, on the beat marked
// last, returns one verdict on whether the text is plausible. A byte can be accepted
// every clock while the input is not stalled; a byte waits in the input register and
// is scanned as it leaves it, and the verdict of a last byte is registered in the
// result register until the sink takes it. Input stall rises only when a last byte
// waits behind a verdict the sink has not taken.
// min_bytes may be written only while no text is in flight; it resets to 64.
// Depends on bbv_pkg, bbv_in_reg, bbv_scan and bbv_out_reg.
module bracket_balance_validator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [bbv_pkg::MIN_W-1:0] i_cfg_wr_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_text_byte,
    input  logic                      i_last_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_plausible
);
    import bbv_pkg::*;

    t_beat in_beat;
    t_beat cur_beat;
    logic  cur_valid;
    logic  advance;
    logic  verdict;

    assign in_beat = '{text_byte: i_text_byte, last_byte: i_last_byte};

    // A non-last byte never needs the result register, so only a last byte can wait.
    assign advance = cur_valid && (!cur_beat.last_byte || !o_out_valid || !i_out_stall);

    bbv_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_beat    (in_beat),
        .i_advance (advance),
        .o_stall   (o_in_stall),
        .o_valid   (cur_valid),
        .o_beat    (cur_beat)
    );

    bbv_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (advance),
        .i_beat        (cur_beat),
        .o_verdict     (verdict)
    );

    bbv_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance && cur_beat.last_byte),
        .i_verdict   (verdict),
        .i_stall     (i_out_stall),
        .o_valid     (o_out_valid),
        .o_plausible (o_plausible)
    );
endmodule

// ===== rtl/bbv_checker.sv =====
// Port-level checks for the bracket balance validator, attached by bind.
// Depends on bracket_balance_validator and bbv_pkg.
module bbv_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic i_last_byte,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_plausible
);
    import bbv_pkg::*;

    // A held verdict must not change or vanish.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_plausible))
        else $error("verdict beat dropped or changed while stalled");

    // Input back-pressure only comes from a verdict stuck at the output.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled verdict");

    // A new verdict appears only after its last byte was taken and passed the input register.
    a_verdict_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall && i_last_byte, 2))
        else $error("verdict without a matching last byte");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("handshake outputs not cleared by reset");
endmodule

bind bracket_balance_validator bbv_checker u_bbv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_last_byte (i_last_byte),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_plausible (o_plausible)
);

// ===== tb/tb.sv =====
// Self-checking testbench for bracket_balance_validator: streams texts one byte per beat
// and checks each end-of-text verdict against a cycle-free scanner written here.
// Depends on bbv_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb;
    import bbv_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 100000;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned BEATS_PER_PHASE = 260;
    localparam int          DIR_ROWS        = 25;

    localparam logic [8*KEY_LEN-1:0] KEY_TEXT = {"mods", "_settings"};

    // Where the expected verdict of a directed row comes from.
    typedef enum logic [1:0] {CHK_MODEL, CHK_FAIL, CHK_PASS} t_verdict_src;
    typedef enum int unsigned {DMG_FLIP, DMG_CUT, DMG_CLOSE, DMG_OPEN_STR, DMG_ESC_END,
                               DMG_NUL} t_damage;

    typedef struct packed {
        logic [7:0]   ch;
        logic         last;
        t_verdict_src src;
    } t_dir_row;

    // Row 0 runs with the reset length floor; the rest with min_bytes = 0.
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{"x",       1'b1, CHK_FAIL},
        '{CH_NUL,    1'b1, CHK_FAIL},
        '{"m", 1'b0, CHK_MODEL}, '{"o", 1'b0, CHK_MODEL}, '{"d", 1'b0, CHK_MODEL},
        '{"s", 1'b0, CHK_MODEL}, '{"_", 1'b0, CHK_MODEL}, '{"s", 1'b0, CHK_MODEL},
        '{"e", 1'b0, CHK_MODEL}, '{"t", 1'b0, CHK_MODEL}, '{"t", 1'b0, CHK_MODEL},
        '{"i", 1'b0, CHK_MODEL}, '{"n", 1'b0, CHK_MODEL}, '{"g", 1'b0, CHK_MODEL},
        '{"s",       1'b1, CHK_PASS},
        '{CH_RBRACE, 1'b1, CHK_FAIL},
        '{CH_QUOTE,  1'b0, CHK_MODEL},
        '{CH_BSLASH, 1'b1, CHK_FAIL},
        '{CH_QUOTE,  1'b0, CHK_MODEL},
        '{CH_BSLASH, 1'b0, CHK_MODEL},
        '{CH_NUL,    1'b0, CHK_MODEL},
        '{CH_QUOTE,  1'b0, CHK_MODEL},
        '{CH_LBRACK, 1'b0, CHK_MODEL},
        '{CH_RBRACK, 1'b0, CHK_MODEL},
        '{8'hFF,     1'b1, CHK_MODEL}
    };

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_wr_en   = 1'b0;
    logic [MIN_W-1:0]    i_cfg_wr_data = '0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_stall;
    logic [7:0]          i_text_byte   = '0;
    logic                i_last_byte   = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall   = 1'b0;
    logic                o_plausible;

    // Scanner state, mirrors what the block tracks for the text in flight.
    logic [CNT_W-1:0]    sc_bytes;
    logic [CNT_W-1:0]    sc_brace;
    logic [CNT_W-1:0]    sc_bracket;
    logic [PROG_W-1:0]   sc_match;
    bit                  sc_in_str;
    bit                  sc_escape;
    bit                  sc_key_seen;
    bit                  sc_failed;
    logic [MIN_W-1:0]    min_len = MIN_BYTES_RST;

    bit                  verdict_q [$];
    t_beat               text_q [$];
    bit                  open_kinds [$];    // 1 = brace, 0 = bracket

    bit                  src_quiet  = 1'b0;
    bit                  sink_quiet = 1'b0;
    int unsigned         n_err      = 0;
    int unsigned         n_beats    = 0;
    int unsigned         n_texts    = 0;
    int unsigned         n_checked  = 0;
    int unsigned         n_cfg      = 0;
    int unsigned         n_cycles   = 0;

    bracket_balance_validator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_text_byte   (i_text_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_plausible   (o_plausible)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] key_byte(input int unsigned idx);
        return KEY_TEXT[8*(KEY_LEN-1-idx) +: 8];
    endfunction

    function automatic void clear_scan();
        sc_bytes    = '0;
        sc_brace    = '0;
        sc_bracket  = '0;
        sc_match    = '0;
        sc_in_str   = 1'b0;
        sc_escape   = 1'b0;
        sc_key_seen = 1'b0;
        sc_failed   = 1'b0;
    endfunction

    // Advances the scanner by one byte; returns the verdict when the byte ends the text.
    function automatic bit scan_byte(input logic [7:0] c, input logic last);
        bit ok;
        if (sc_bytes >= MAX_BYTES) begin
            sc_failed = 1'b1;
        end else begin
            sc_bytes++;
        end

        // No prefix of the key reappears inside it, so a miss restarts the search cleanly.
        if (sc_match < KEY_LEN && c == key_byte(sc_match)) begin
            sc_match++;
        end else begin
            sc_match = (c == key_byte(0)) ? PROG_W'(1) : PROG_W'(0);
        end
        if (sc_match == KEY_LEN) begin
            sc_key_seen = 1'b1;
            sc_match    = '0;
        end

        if (sc_escape) begin
            sc_escape = 1'b0;
        end else if (c == CH_NUL) begin
            sc_failed = 1'b1;
        end else if (sc_in_str) begin
            if (c == CH_BSLASH) begin
                sc_escape = 1'b1;
            end else if (c == CH_QUOTE) begin
                sc_in_str = 1'b0;
            end
        end else begin
            case (c)
                CH_QUOTE:  sc_in_str = 1'b1;
                CH_LBRACE: if (sc_brace >= MAX_BYTES) sc_failed = 1'b1; else sc_brace++;
                CH_RBRACE: if (sc_brace == 0) sc_failed = 1'b1; else sc_brace--;
                CH_LBRACK: if (sc_bracket >= MAX_BYTES) sc_failed = 1'b1; else sc_bracket++;
                CH_RBRACK: if (sc_bracket == 0) sc_failed = 1'b1; else sc_bracket--;
                default: ;
            endcase
        end

        if (!last) return 1'b0;
        ok = !sc_failed && sc_key_seen && (sc_bytes >= min_len) && !sc_in_str &&
             !sc_escape && sc_brace == 0 && sc_bracket == 0;
        clear_scan();
        return ok;
    endfunction

    task automatic report_mismatch(input string what);
        n_err++;
        if (n_err <= 40) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    function automatic void add_byte(input logic [7:0] c);
        text_q = {text_q, t_beat'({c, 1'b0})};
    endfunction

    function automatic void add_key();
        for (int unsigned i = 0; i < KEY_LEN; i++) add_byte(key_byte(i));
    endfunction

    function automatic void add_close();
        add_byte(open_kinds[$] ? CH_RBRACE : CH_RBRACK);
        void'(open_kinds.pop_back());
    endfunction

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 6))
            0:       return CH_NUL;
            1:       return CH_BSLASH;
            2:       return CH_QUOTE;
            3:       return CH_LBRACE;
            4:       return CH_RBRACE;
            5:       return CH_LBRACK;
            default: return CH_RBRACK;
        endcase
    endfunction

    // Builds the next random text in text_q: mostly well nested with the key somewhere,
    // some of it damaged afterwards, and a little raw noise.
    function automatic void make_text();
        int          target;
        int          key_at;
        int unsigned kind;
        int unsigned pick;
        int unsigned cut;
        bit          want_key;
        logic [7:0]  c;
        text_q.delete();
        open_kinds.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            if ($urandom_range(0, 3) == 0) add_key();
            repeat ($urandom_range(1, 40))
                add_byte($urandom_range(0, 1) ? pick_special() : 8'($urandom_range(0, 255)));
        end else begin
            if (min_len <= 300 && $urandom_range(0, 9) < 7) begin
                target = int'(min_len) + int'($urandom_range(0, 24)) - 12;
                if (target < 1) target = 1;
            end else begin
                target = $urandom_range(1, 40);
            end
            want_key = ($urandom_range(0, 19) != 0);
            key_at   = $urandom_range(0, target);
            while (text_q.size() < target) begin
                pick = $urandom_range(0, 99);
                if (want_key && text_q.size() >= key_at) begin
                    add_key();
                    want_key = 1'b0;
                end else if (pick < 15) begin
                    open_kinds = {open_kinds, bit'($urandom_range(0, 1))};
                    add_byte(open_kinds[$] ? CH_LBRACE : CH_LBRACK);
                end else if (pick < 30 && open_kinds.size() != 0) begin
                    add_close();
                end else if (pick < 45) begin
                    add_byte(CH_QUOTE);
                    repeat ($urandom_range(0, 8)) begin
                        cut = $urandom_range(0, 29);
                        if (cut < 6) begin
                            add_byte(CH_BSLASH);
                            add_byte(8'($urandom_range(0, 255)));
                        end else if (cut == 6) begin
                            add_key();
                        end else begin
                            c = 8'($urandom_range(1, 255));
                            if (c == CH_QUOTE || c == CH_BSLASH) c = "a";
                            add_byte(c);
                        end
                    end
                    add_byte(CH_QUOTE);
                end else if ($urandom_range(0, 1)) begin
                    // Stray key letters exercise partial matches.
                    add_byte(key_byte($urandom_range(0, KEY_LEN - 1)));
                end else begin
                    c = 8'($urandom_range(8'h20, 8'h7E));
                    case (c) inside
                        CH_QUOTE, CH_BSLASH, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK:
                            c = ",";
                        default: ;
                    endcase
                    add_byte(c);
                end
            end
            if (want_key) add_key();
            while (open_kinds.size() != 0) add_close();

            if (kind >= 72) begin
                pick = $urandom_range(0, text_q.size() - 1);
                case (t_damage'($urandom_range(0, 5)))
                    DMG_FLIP: text_q[pick].text_byte = 8'($urandom_range(0, 255));
                    DMG_CUT: begin
                        if (text_q.size() > 1) begin
                            cut = $urandom_range(1, text_q.size() - 1);
                            while (text_q.size() > cut) void'(text_q.pop_back());
                        end
                    end
                    DMG_CLOSE:    add_byte($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACK);
                    DMG_OPEN_STR: add_byte(CH_QUOTE);
                    DMG_ESC_END: begin
                        add_byte(CH_QUOTE);
                        add_byte(CH_BSLASH);
                    end
                    default:      text_q[pick].text_byte = CH_NUL;
                endcase
            end
        end
        text_q[text_q.size() - 1].last_byte = 1'b1;
    endfunction

    // Offers one beat, waits for it to be taken and records the verdict it implies.
    task automatic send_beat(input t_beat b, input t_verdict_src src);
        bit verdict;
        if (!src_quiet && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= b.text_byte;
        i_last_byte <= b.last_byte;
        do @(posedge i_clk); while (o_in_stall);
        n_beats++;
        verdict = scan_byte(b.text_byte, b.last_byte);
        if (b.last_byte) begin
            n_texts++;
            verdict_q = {verdict_q, bit'((src == CHK_MODEL) ? verdict : (src == CHK_PASS))};
        end
    endtask

    // The block must be idle for a write, so let any verdict still in the pipe drain first.
    task automatic write_min(input logic [MIN_W-1:0] value);
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        min_len = value;
        n_cfg++;
    endtask

    always @(posedge i_clk) begin : sink
        bit want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("verdict %b with none expected", o_plausible));
            end else begin
                want = verdict_q.pop_front();
                n_checked++;
                if (o_plausible !== want)
                    report_mismatch($sformatf("plausible %b, expected %b (verdict %0d)",
                                              o_plausible, want, n_checked));
            end
        end
        i_out_stall <= i_rst_n && !sink_quiet && ($urandom_range(0, 99) < 20);
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d verdicts pending",
                     n_cycles, verdict_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [MIN_W-1:0] min_plan [6];
        int unsigned      phase_start;

        min_plan = '{MIN_W'(MAX_BYTES), MIN_W'(13), MIN_W'(64), MIN_W'(0),
                     MIN_W'(MAX_BYTES - 1), MIN_W'($urandom_range(14, 120))};
        clear_scan();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (i == 1) write_min('0);
            send_beat(t_beat'({dir_tab[i].ch, dir_tab[i].last}), dir_tab[i].src);
        end

        for (int p = 0; p < 6; p++) begin
            write_min(min_plan[p]);
            src_quiet   = (p == 1);
            sink_quiet  = (p == 1);
            phase_start = n_beats;
            while (n_beats - phase_start < BEATS_PER_PHASE) begin
                make_text();
                foreach (text_q[j]) send_beat(text_q[j], CHK_MODEL);
            end
        end

        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Streamed %0d bytes in %0d texts under %0d min_bytes settings;",
                 n_beats, n_texts, n_cfg);
        $display("%0d verdicts compared, %0d mismatches.", n_checked, n_err);
        if (n_err == 0 && verdict_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
